// ===== rtl/ktksl_pkg.sv =====
// Shared types and constants of the keyed top-k score list.
`default_nettype none

package ktksl_pkg;

  localparam int KEY_W   = 32;
  localparam int SCORE_W = 32;

  // Operation codes carried in the operation field of an input word.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [2:0]         list_index;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         out_list;
    logic [3:0]         position;
    logic [KEY_W-1:0]   out_key;
    logic [SCORE_W-1:0] out_score;
    logic               entry_valid;
    logic [3:0]         list_count;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Control handed from the sequencer to every cell of the chain.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_CALC,
    ST_MERGE,
    ST_WRITE,
    ST_EMPTY
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/ktksl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ktksl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ktksl_cell.sv =====
// One cell of the entry chain: holds an entry and passes it towards the head.
`default_nettype none

module ktksl_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ktksl_pkg::cell_ctl_t        ctl_i,
  input  wire ktksl_pkg::entry_t           load_entry_i,
  input  wire logic                        load_valid_i,
  input  wire ktksl_pkg::entry_t           next_entry_i,
  input  wire logic                        next_valid_i,
  input  wire logic [ktksl_pkg::KEY_W-1:0] key_i,
  output      ktksl_pkg::entry_t           entry_o,
  output      logic                        valid_o,
  output      logic                        match_o
);

  ktksl_pkg::entry_t entry_q;
  logic              valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= load_valid_i;
    end else if (ctl_i.shift) begin
      valid_q <= next_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      entry_q <= load_entry_i;
    end else if (ctl_i.shift) begin
      entry_q <= next_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  // The entry carries the key of the word under work.
  assign match_o = valid_q && (entry_q.key == key_i);

endmodule

`default_nettype wire

// ===== rtl/keyed_top_k_score_list.sv =====
// Top level of the keyed top-k score list: sequencer, entry chain and list RAM.
// Flow: an accepted update passes through the READ, LOAD and CALC states before the MERGE
// state shows its first result word; a clear, or a word for a list that does not exist, shows
// its report from the EMPTY state. A new word is taken only back in IDLE, after the merge
// and the WRITE state of an update, or after the report of a clear. Output stalls hold the
// merge. Reset marks every list empty at once through per-list valid bits.
`default_nettype none

module keyed_top_k_score_list #(
  parameter int LIST_LIMIT = 10,
  parameter int NUM_LISTS  = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire ktksl_pkg::in_word_t  in_word_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      ktksl_pkg::out_word_t out_word_o
);

  // Widths that follow from the parameters.
  localparam int LW = $clog2(LIST_LIMIT + 1);                 // list length
  localparam int IW = (LIST_LIMIT > 1) ? $clog2(LIST_LIMIT) : 1;  // rank index
  localparam int LA = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;    // list address
  localparam int EW = ktksl_pkg::ENTRY_W;
  // One RAM row holds a whole list: its entries in rank order and its length.
  localparam int RW = LIST_LIMIT * EW + LW;

  ktksl_pkg::state_e state_q, state_d;

  ktksl_pkg::in_word_t  item_q;
  logic [LA-1:0]        addr_q;
  logic [NUM_LISTS-1:0] row_valid_q;
  logic [LW-1:0]        old_len_q;
  logic [LW-1:0]        new_len_q;
  logic [LW-1:0]        e_q;
  logic                 ins_q;
  ktksl_pkg::entry_t    wb_q [LIST_LIMIT];

  logic                 out_valid_q;
  ktksl_pkg::out_word_t out_q, out_d;

  // Handshake and datapath controls.
  logic in_fire, in_range, out_free;
  logic ram_re, ram_we;
  logic merge_step, take_new, merge_emit, merge_last, empty_emit, emit;
  ktksl_pkg::cell_ctl_t cell_ctl;
  ktksl_pkg::entry_t    emit_entry;

  logic [RW-1:0] ram_rdata, ram_wdata;
  logic [LW-1:0] rd_len;
  logic          match_any;
  logic [LW-1:0] new_len_d;

  // Chain wiring; cell 0 is the head, which always shows the best old entry left.
  ktksl_pkg::entry_t     cell_entry [LIST_LIMIT];
  ktksl_pkg::entry_t     nxt_entry  [LIST_LIMIT];
  logic [LIST_LIMIT-1:0] cell_valid, nxt_valid, cell_match, ld_valid;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign in_range = (32'(in_word_i.list_index) < 32'(NUM_LISTS));
  assign out_free = !out_valid_q || !out_stall_i;

  // A list whose row was never written, or was cleared, reads as empty.
  assign rd_len = row_valid_q[addr_q] ? ram_rdata[LIST_LIMIT*EW +: LW] : '0;

  // Removing the old entry of the key and inserting the new one keeps the length;
  // otherwise the list grows by one unless it is full, in which case one entry is
  // pushed out or the new one is dropped.
  assign match_any = |cell_match;
  always_comb begin
    if (match_any) begin
      new_len_d = old_len_q;
    end else if (old_len_q == LW'(LIST_LIMIT)) begin
      new_len_d = old_len_q;
    end else begin
      new_len_d = old_len_q + LW'(1);
    end
  end

  ktksl_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_LISTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  for (genvar i = 0; i < LIST_LIMIT; i++) begin : g_cell
    if (i == LIST_LIMIT - 1) begin : g_tail
      assign nxt_entry[i] = '0;
      assign nxt_valid[i] = 1'b0;
    end else begin : g_inner
      assign nxt_entry[i] = cell_entry[i+1];
      assign nxt_valid[i] = cell_valid[i+1];
    end

    assign ld_valid[i] = (LW'(i) < rd_len);

    ktksl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl),
      .load_entry_i (ktksl_pkg::entry_t'(ram_rdata[i*EW +: EW])),
      .load_valid_i (ld_valid[i]),
      .next_entry_i (nxt_entry[i]),
      .next_valid_i (nxt_valid[i]),
      .key_i        (item_q.key),
      .entry_o      (cell_entry[i]),
      .valid_o      (cell_valid[i]),
      .match_o      (cell_match[i])
    );
  end

  // Merge step: the new entry goes ahead of the first old entry with a lower
  // score; an old entry with the same key is stepped over without a result.
  assign take_new   = !ins_q &&
                      (!cell_valid[0] || (cell_entry[0].score < item_q.score));
  assign merge_emit = merge_step && (take_new || !cell_match[0]);
  assign merge_last = merge_emit && (e_q == new_len_q - LW'(1));
  assign emit       = merge_emit || empty_emit;

  always_comb begin
    emit_entry.key   = take_new ? item_q.key   : cell_entry[0].key;
    emit_entry.score = take_new ? item_q.score : cell_entry[0].score;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ktksl_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!in_range || (in_word_i.operation == ktksl_pkg::OP_CLEAR)) begin
            state_d = ktksl_pkg::ST_EMPTY;
          end else begin
            state_d = ktksl_pkg::ST_READ;
          end
        end
      end
      ktksl_pkg::ST_READ:  state_d = ktksl_pkg::ST_LOAD;
      ktksl_pkg::ST_LOAD:  state_d = ktksl_pkg::ST_CALC;
      ktksl_pkg::ST_CALC:  state_d = ktksl_pkg::ST_MERGE;
      ktksl_pkg::ST_MERGE: begin
        if (merge_last) begin
          state_d = ktksl_pkg::ST_WRITE;
        end
      end
      ktksl_pkg::ST_WRITE: state_d = ktksl_pkg::ST_IDLE;
      ktksl_pkg::ST_EMPTY: begin
        if (out_free) begin
          state_d = ktksl_pkg::ST_IDLE;
        end
      end
      default: state_d = ktksl_pkg::ST_IDLE;
    endcase
  end

  // State decoding for the datapath.
  always_comb begin
    in_stall_o     = (state_q != ktksl_pkg::ST_IDLE);
    ram_re         = (state_q == ktksl_pkg::ST_READ);
    ram_we         = (state_q == ktksl_pkg::ST_WRITE);
    merge_step     = (state_q == ktksl_pkg::ST_MERGE) && out_free;
    empty_emit     = (state_q == ktksl_pkg::ST_EMPTY) && out_free;
    cell_ctl.load  = (state_q == ktksl_pkg::ST_LOAD);
    cell_ctl.shift = merge_step && !take_new;
  end

  // Result word: a list entry during the merge, or the empty-list report.
  always_comb begin
    out_d.out_list = item_q.list_index;
    if (empty_emit) begin
      out_d.position    = '0;
      out_d.out_key     = '0;
      out_d.out_score   = '0;
      out_d.entry_valid = 1'b0;
      out_d.list_count  = '0;
      out_d.last        = 1'b1;
    end else begin
      out_d.position    = 4'(e_q);
      out_d.out_key     = emit_entry.key;
      out_d.out_score   = emit_entry.score;
      out_d.entry_valid = 1'b1;
      out_d.list_count  = 4'(new_len_q);
      out_d.last        = merge_last;
    end
  end

  // Write-back row assembled from the merged entries.
  always_comb begin
    ram_wdata = '0;
    for (int i = 0; i < LIST_LIMIT; i++) begin
      ram_wdata[i*EW +: EW] = wb_q[i];
    end
    ram_wdata[LIST_LIMIT*EW +: LW] = new_len_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ktksl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      old_len_q   <= '0;
      new_len_q   <= '0;
      e_q         <= '0;
      ins_q       <= 1'b0;
    end else begin
      state_q <= state_d;

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // A clear only has to mark the row empty; its old contents are never used.
      if (in_fire && in_range && (in_word_i.operation == ktksl_pkg::OP_CLEAR)) begin
        row_valid_q[LA'(in_word_i.list_index)] <= 1'b0;
      end else if (ram_we) begin
        row_valid_q[addr_q] <= 1'b1;
      end

      if (cell_ctl.load) begin
        old_len_q <= rd_len;
        e_q       <= '0;
        ins_q     <= 1'b0;
      end else begin
        if (merge_emit) begin
          e_q <= e_q + LW'(1);
        end
        if (merge_step && take_new) begin
          ins_q <= 1'b1;
        end
      end

      if (state_q == ktksl_pkg::ST_CALC) begin
        new_len_q <= new_len_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_word_i;
      addr_q <= LA'(in_word_i.list_index);
    end
    if (emit) begin
      out_q <= out_d;
    end
    if (merge_emit) begin
      wb_q[e_q[IW-1:0]] <= emit_entry;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/ktksl_checker.sv =====
// Port-level checks of the keyed top-k score list and their binding.
`default_nettype none

module ktksl_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire ktksl_pkg::out_word_t out_word_o
);

  // A held result word stays in place until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // Only one word is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is in work");

  // The empty-list report is a run of its own.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.entry_valid |->
      out_word_o.last && (out_word_o.list_count == 4'd0) &&
      (out_word_o.position == 4'd0))
    else $error("malformed empty-list report");

  // The final entry of a run sits at the last rank of the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.entry_valid && out_word_o.last |->
      out_word_o.position == 4'(out_word_o.list_count - 4'd1))
    else $error("last entry not at the final rank");

endmodule

bind keyed_top_k_score_list ktksl_checker u_ktksl_checker (.*);

`default_nettype wire

// ===== test/tb_keyed_top_k_score_list.sv =====
// Self-checking testbench for the keyed top-k score list: directed cases, then random traffic.
`default_nettype none

module tb_keyed_top_k_score_list;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default sizes, and the predictor mirrors them.
  localparam int RANK_LIMIT = 10;
  localparam int LIST_COUNT = 8;

  // Clock, reset and the two channels. Every input starts at a known value.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  ktksl_pkg::in_word_t  in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  ktksl_pkg::out_word_t out_word_o;

  // Predicted contents of every list, held the way the block ranks them.
  logic [ktksl_pkg::KEY_W-1:0]   rank_key   [LIST_COUNT][RANK_LIMIT];
  logic [ktksl_pkg::SCORE_W-1:0] rank_score [LIST_COUNT][RANK_LIMIT];
  int unsigned                   rank_len   [LIST_COUNT];

  // Report words still owed by the block, oldest first.
  ktksl_pkg::out_word_t expected_ranks[$];
  ktksl_pkg::out_word_t oldest_rank;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Small pool of keys, so that random updates hit keys already in a list.
  logic [ktksl_pkg::KEY_W-1:0] key_pool [16];

  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned clears_sent   = 0;
  int unsigned ranks_checked = 0;
  int unsigned full_reports  = 0;

  keyed_top_k_score_list #(
    .LIST_LIMIT (RANK_LIMIT),
    .NUM_LISTS  (LIST_COUNT)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // A 2 ns clock that starts low, so that no edge falls at time zero.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Every mismatch comes through here: one line, one count.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch in %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
  endtask

  // Predictor. Applies one accepted word to the predicted lists and queues the
  // report words that the block owes for it.
  task automatic rank_update(input ktksl_pkg::in_word_t w);
    int unsigned          lst;
    int unsigned          n;
    int unsigned          i;
    int unsigned          j;
    int unsigned          p;
    int unsigned          top;
    bit                   hit;
    ktksl_pkg::out_word_t r;
    lst = 32'(w.list_index);
    if (w.operation == ktksl_pkg::OP_CLEAR) begin
      rank_len[lst] = 0;
    end else begin
      n = rank_len[lst];
      // An entry with the same key is taken out first.
      i   = 0;
      hit = 1'b0;
      while (i < n && !hit) begin
        if (rank_key[lst][i] == w.key) hit = 1'b1;
        else i++;
      end
      if (hit) begin
        for (j = i; j + 1 < n; j++) begin
          rank_key[lst][j]   = rank_key[lst][j+1];
          rank_score[lst][j] = rank_score[lst][j+1];
        end
        n--;
      end
      // The new entry goes behind every entry that scores at least as high.
      p = 0;
      while (p < n && rank_score[lst][p] >= w.score) p++;
      if (p < RANK_LIMIT) begin
        top = (n < RANK_LIMIT) ? n : RANK_LIMIT - 1;
        for (j = top; j > p; j--) begin
          rank_key[lst][j]   = rank_key[lst][j-1];
          rank_score[lst][j] = rank_score[lst][j-1];
        end
        rank_key[lst][p]   = w.key;
        rank_score[lst][p] = w.score;
        n = top + 1;
      end
      rank_len[lst] = n;
    end
    n = rank_len[lst];
    if (n == RANK_LIMIT) full_reports++;
    if (n == 0) begin
      // An empty list is reported by a single word marked not valid.
      r = '0;
      r.out_list = w.list_index;
      r.last     = 1'b1;
      expected_ranks.push_back(r);
    end else begin
      for (i = 0; i < n; i++) begin
        r.out_list    = w.list_index;
        r.position    = i[3:0];
        r.out_key     = rank_key[lst][i];
        r.out_score   = rank_score[lst][i];
        r.entry_valid = 1'b1;
        r.list_count  = n[3:0];
        r.last        = (i + 1 == n);
        expected_ranks.push_back(r);
      end
    end
  endtask

  // Checker. Each report word taken from the block is held against the oldest
  // prediction, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_ranks.size() == 0) begin
        report_mismatch("unexpected report word", out_word_o[31:0], '0);
      end else begin
        oldest_rank = expected_ranks.pop_front();
        ranks_checked++;
        if (out_word_o.out_list !== oldest_rank.out_list)
          report_mismatch("out_list", 32'(out_word_o.out_list), 32'(oldest_rank.out_list));
        if (out_word_o.position !== oldest_rank.position)
          report_mismatch("position", 32'(out_word_o.position), 32'(oldest_rank.position));
        if (out_word_o.out_key !== oldest_rank.out_key)
          report_mismatch("out_key", out_word_o.out_key, oldest_rank.out_key);
        if (out_word_o.out_score !== oldest_rank.out_score)
          report_mismatch("out_score", out_word_o.out_score, oldest_rank.out_score);
        if (out_word_o.entry_valid !== oldest_rank.entry_valid)
          report_mismatch("entry_valid", 32'(out_word_o.entry_valid),
                          32'(oldest_rank.entry_valid));
        if (out_word_o.list_count !== oldest_rank.list_count)
          report_mismatch("list_count", 32'(out_word_o.list_count),
                          32'(oldest_rank.list_count));
        if (out_word_o.last !== oldest_rank.last)
          report_mismatch("last", 32'(out_word_o.last), 32'(oldest_rank.last));
      end
    end
  end

  // Sends one word. The sender may first idle for a while; valid then stays
  // high, with the payload held, until the block takes the word. On return
  // valid is still high, so that the next word can follow without a gap.
  task automatic send_word(input ktksl_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    words_sent++;
    if (w.operation == ktksl_pkg::OP_CLEAR) clears_sent++;
    rank_update(w);
  endtask

  // Convenience wrappers for the directed cases.
  task automatic send_update(input int unsigned lst,
                             input logic [ktksl_pkg::KEY_W-1:0] key,
                             input logic [ktksl_pkg::SCORE_W-1:0] score);
    ktksl_pkg::in_word_t w;
    w.operation  = ktksl_pkg::OP_UPDATE;
    w.list_index = lst[2:0];
    w.key        = key;
    w.score      = score;
    send_word(w);
  endtask

  task automatic send_clear(input int unsigned lst);
    ktksl_pkg::in_word_t w;
    w.operation  = ktksl_pkg::OP_CLEAR;
    w.list_index = lst[2:0];
    w.key        = $urandom();
    w.score      = $urandom();
    send_word(w);
  endtask

  // The sender holds off until every report word owed so far has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk_i);
  endtask

  // A clear of a list that was never written, and of the highest list.
  task automatic test_clear_empty();
    send_clear(0);
    send_clear(7);
  endtask

  // Keys and scores at both ends of their range, on the highest list, which is
  // then cleared while it holds entries.
  task automatic test_field_extremes();
    send_update(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_update(7, 32'h0000_0000, 32'h0000_0000);
    send_update(7, 32'hA5A5_5A5A, 32'h0001_0000);
    send_clear(7);
  endtask

  // Equal scores keep their order of arrival: each newcomer goes last.
  task automatic test_equal_scores();
    send_update(1, 32'd1, 32'd50);
    send_update(1, 32'd2, 32'd50);
    send_update(1, 32'd3, 32'd50);
  endtask

  // A key that is already present moves to the rank of its new score.
  task automatic test_key_rescore();
    send_update(1, 32'd2, 32'd60);
    send_update(1, 32'd2, 32'd10);
  endtask

  // A full list: a low newcomer is dropped, a high one pushes the lowest out,
  // and a key inside the list can still be moved to the bottom rank.
  task automatic test_full_list();
    int unsigned i;
    for (i = 0; i < RANK_LIMIT; i++) send_update(2, 100 + i, 1000 - 10 * i);
    send_update(2, 32'd200, 32'd5);
    send_update(2, 32'd201, 32'd2000);
    send_update(2, 32'd105, 32'd1);
  endtask

  // Random traffic for one phase of idling and stalling. Most words reuse keys
  // from the pool, and scores are often small or at either end of their range,
  // so that lists fill, ties occur and keys get rescored; the rest is fully random.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned count);
    ktksl_pkg::in_word_t w;
    int unsigned         k;
    int unsigned         pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < count; k++) begin
      w.operation  = ($urandom_range(99) < 6) ? ktksl_pkg::OP_CLEAR : ktksl_pkg::OP_UPDATE;
      w.list_index = 3'($urandom_range(LIST_COUNT - 1));
      w.key        = ($urandom_range(9) < 7) ? key_pool[$urandom_range(15)] : $urandom();
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2, 3: w.score = $urandom_range(7);
        4:          w.score = 32'h0000_0000;
        5:          w.score = 32'hFFFF_FFFF;
        default:    w.score = $urandom();
      endcase
      send_word(w);
    end
    wait_drained();
  endtask

  // Stimulus: reset once, the directed cases, then four random phases.
  initial begin
    int unsigned i;
    for (i = 0; i < LIST_COUNT; i++) rank_len[i] = 0;
    for (i = 0; i < 16; i++) key_pool[i] = $urandom();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_clear_empty();
    test_field_extremes();
    test_equal_scores();
    test_key_rescore();
    test_full_list();
    wait_drained();

    test_random_traffic(0, 0, 55);
    test_random_traffic(79, 0, 55);
    test_random_traffic(0, 79, 55);
    test_random_traffic(8, 8, 55);

    // Everything has been taken; allow time for any stray word to show up.
    recv_stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (expected_ranks.size() != 0)
      report_mismatch("report words never delivered", expected_ranks.size(), 0);

    $display("Sent %0d words (%0d clears) and checked %0d report words.",
             words_sent, clears_sent, ranks_checked);
    $display("%0d reports showed a full list; %0d mismatches were found.",
             full_reports, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
